@@ hw/rtl/scd_pkg.sv @@
// Shared types, constants and character ROMs for the scan code decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package scd_pkg;

   // Field widths and key map depth
   localparam int NUM_KEYS = 128;
   localparam int KEY_W    = $clog2(NUM_KEYS);
   localparam int SCAN_W   = 8;
   localparam int CHAR_W   = 7;

   // Special scan bytes and key indexes
   localparam logic [SCAN_W-1:0] SCAN_EXT_PREFIX = 8'hE0;
   localparam logic [SCAN_W-1:0] SCAN_PAUSE      = 8'hE1;
   localparam logic [KEY_W-1:0]  KEY_LSHIFT      = 7'h2A;
   localparam logic [KEY_W-1:0]  KEY_RSHIFT      = 7'h36;
   localparam logic [KEY_W-1:0]  KEY_CAPS        = 7'h3A;

   // Letter bounds and case offset
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 7'd90;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'd122;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 7'd32;

   // Key map write port
   typedef struct packed {
      logic             en;
      logic [KEY_W-1:0] addr;
      logic             data;
   } map_wr_type;

   // Decoded fields of one transaction, all but the probed key bit
   typedef struct packed {
      logic              char_valid;
      logic [CHAR_W-1:0] char_code;
      logic [KEY_W-1:0]  last_make;
      logic              pause_on;
      logic              capslock_on;
   } dec_result_type;

   // Unshifted character ROM
   function automatic logic [CHAR_W-1:0] rom_plain(input logic [KEY_W-1:0] k);
      unique case (k)
         7'h01: rom_plain = 7'd27;                         // escape
         7'h02: rom_plain = 7'd49;  7'h03: rom_plain = 7'd50;
         7'h04: rom_plain = 7'd51;  7'h05: rom_plain = 7'd52;
         7'h06: rom_plain = 7'd53;  7'h07: rom_plain = 7'd54;
         7'h08: rom_plain = 7'd55;  7'h09: rom_plain = 7'd56;
         7'h0A: rom_plain = 7'd57;  7'h0B: rom_plain = 7'd48;
         7'h0C: rom_plain = 7'd45;  7'h0D: rom_plain = 7'd61;
         7'h0E: rom_plain = 7'd8;   7'h0F: rom_plain = 7'd9;
         7'h10: rom_plain = 7'd113; 7'h11: rom_plain = 7'd119;   // q w
         7'h12: rom_plain = 7'd101; 7'h13: rom_plain = 7'd114;   // e r
         7'h14: rom_plain = 7'd116; 7'h15: rom_plain = 7'd121;   // t y
         7'h16: rom_plain = 7'd117; 7'h17: rom_plain = 7'd105;   // u i
         7'h18: rom_plain = 7'd111; 7'h19: rom_plain = 7'd112;   // o p
         7'h1A: rom_plain = 7'd91;  7'h1B: rom_plain = 7'd93;    // [ ]
         7'h1C: rom_plain = 7'd13;                               // enter
         7'h1E: rom_plain = 7'd97;  7'h1F: rom_plain = 7'd115;   // a s
         7'h20: rom_plain = 7'd100; 7'h21: rom_plain = 7'd102;   // d f
         7'h22: rom_plain = 7'd103; 7'h23: rom_plain = 7'd104;   // g h
         7'h24: rom_plain = 7'd106; 7'h25: rom_plain = 7'd107;   // j k
         7'h26: rom_plain = 7'd108; 7'h27: rom_plain = 7'd59;    // l ;
         7'h28: rom_plain = 7'd39;  7'h29: rom_plain = 7'd96;    // ' `
         7'h2B: rom_plain = 7'd92;                               // backslash
         7'h2C: rom_plain = 7'd122; 7'h2D: rom_plain = 7'd120;   // z x
         7'h2E: rom_plain = 7'd99;  7'h2F: rom_plain = 7'd118;   // c v
         7'h30: rom_plain = 7'd98;  7'h31: rom_plain = 7'd110;   // b n
         7'h32: rom_plain = 7'd109; 7'h33: rom_plain = 7'd44;    // m ,
         7'h34: rom_plain = 7'd46;  7'h35: rom_plain = 7'd47;    // . /
         7'h37: rom_plain = 7'd42;  7'h39: rom_plain = 7'd32;    // * space
         7'h4A: rom_plain = 7'd45;  7'h4E: rom_plain = 7'd43;    // keypad - +
         7'h53: rom_plain = 7'd127;                              // delete
         default: rom_plain = '0;
      endcase
   endfunction

   // Shifted character ROM
   function automatic logic [CHAR_W-1:0] rom_shift(input logic [KEY_W-1:0] k);
      unique case (k)
         7'h01: rom_shift = 7'd27;
         7'h02: rom_shift = 7'd33;  7'h03: rom_shift = 7'd64;    // ! @
         7'h04: rom_shift = 7'd35;  7'h05: rom_shift = 7'd36;    // # $
         7'h06: rom_shift = 7'd37;  7'h07: rom_shift = 7'd94;    // % ^
         7'h08: rom_shift = 7'd38;  7'h09: rom_shift = 7'd42;    // & *
         7'h0A: rom_shift = 7'd40;  7'h0B: rom_shift = 7'd41;    // ( )
         7'h0C: rom_shift = 7'd95;  7'h0D: rom_shift = 7'd43;    // _ +
         7'h0E: rom_shift = 7'd8;   7'h0F: rom_shift = 7'd9;
         7'h10: rom_shift = 7'd81;  7'h11: rom_shift = 7'd87;    // Q W
         7'h12: rom_shift = 7'd69;  7'h13: rom_shift = 7'd82;    // E R
         7'h14: rom_shift = 7'd84;  7'h15: rom_shift = 7'd89;    // T Y
         7'h16: rom_shift = 7'd85;  7'h17: rom_shift = 7'd73;    // U I
         7'h18: rom_shift = 7'd79;  7'h19: rom_shift = 7'd80;    // O P
         7'h1A: rom_shift = 7'd123; 7'h1B: rom_shift = 7'd125;   // { }
         7'h1C: rom_shift = 7'd13;
         7'h1E: rom_shift = 7'd65;  7'h1F: rom_shift = 7'd83;    // A S
         7'h20: rom_shift = 7'd68;  7'h21: rom_shift = 7'd70;    // D F
         7'h22: rom_shift = 7'd71;  7'h23: rom_shift = 7'd72;    // G H
         7'h24: rom_shift = 7'd74;  7'h25: rom_shift = 7'd75;    // J K
         7'h26: rom_shift = 7'd76;  7'h27: rom_shift = 7'd58;    // L :
         7'h28: rom_shift = 7'd34;  7'h29: rom_shift = 7'd126;   // " ~
         7'h2B: rom_shift = 7'd124;                              // |
         7'h2C: rom_shift = 7'd90;  7'h2D: rom_shift = 7'd88;    // Z X
         7'h2E: rom_shift = 7'd67;  7'h2F: rom_shift = 7'd86;    // C V
         7'h30: rom_shift = 7'd66;  7'h31: rom_shift = 7'd78;    // B N
         7'h32: rom_shift = 7'd77;  7'h33: rom_shift = 7'd60;    // M <
         7'h34: rom_shift = 7'd62;  7'h35: rom_shift = 7'd63;    // > ?
         7'h37: rom_shift = 7'd42;  7'h39: rom_shift = 7'd32;
         7'h4A: rom_shift = 7'd45;  7'h4E: rom_shift = 7'd43;
         7'h53: rom_shift = 7'd127;
         default: rom_shift = '0;
      endcase
   endfunction

   // Extended (E0-prefixed) character ROM: keypad enter and keypad slash
   function automatic logic [CHAR_W-1:0] rom_ext(input logic [KEY_W-1:0] k);
      unique case (k)
         7'h1C:   rom_ext = 7'd13;
         7'h35:   rom_ext = 7'd47;
         default: rom_ext = '0;
      endcase
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scd_req_if.sv @@
// Request channel of the scan code decoder: one scan byte and a probe index.
// Depends on scd_pkg for field widths.
`default_nettype none

interface scd_req_if
   import scd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [SCAN_W-1:0] scan_byte;
   logic [KEY_W-1:0]  probe_key;

   modport source (output valid, output scan_byte, output probe_key, input ready);
   modport sink   (input valid, input scan_byte, input probe_key, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/scd_rsp_if.sv @@
// Response channel of the scan code decoder: character and status fields.
// Depends on scd_pkg for field widths.
`default_nettype none

interface scd_rsp_if
   import scd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              char_valid;
   logic [CHAR_W-1:0] char_code;
   logic [KEY_W-1:0]  last_make;
   logic              pause_on;
   logic              capslock_on;
   logic              probe_down;

   modport source (output valid, output char_valid, output char_code, output last_make,
                   output pause_on, output capslock_on, output probe_down, input ready);
   modport sink   (input valid, input char_valid, input char_code, input last_make,
                   input pause_on, input capslock_on, input probe_down, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/scd_key_map.sv @@
// Held-key map: single-bit RAM with one write and one registered read port,
// write-to-read forwarding and a clearing sweep after reset. Uses scd_pkg.
`default_nettype none

module scd_key_map
   import scd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire map_wr_type       wr,
   input  wire logic             rd_en,
   input  wire logic [KEY_W-1:0] rd_addr,
   output logic                  held,
   output logic                  clear_busy
);

   logic             mem [NUM_KEYS];
   logic             rd_data_ff;
   logic             fwd_hit_ff;
   logic             fwd_data_ff;
   logic             busy_ff;
   logic             busy_in;
   logic [KEY_W-1:0] clr_addr_ff;
   logic [KEY_W-1:0] clr_addr_in;

   // Sweep every entry to zero after reset
   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == KEY_W'(NUM_KEYS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // RAM: clear or update one entry, read one entry
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Remember a same-cycle write to the read address; the RAM returns old data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_hit_ff  <= wr.en && (wr.addr == rd_addr);
         fwd_data_ff <= wr.data;
      end
   end

   assign held       = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign clear_busy = busy_ff;

`ifndef ASSERT_OFF
   // A read that collides with a write returns the written bit
   a_fwd_collision: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr.en && !busy_ff && (wr.addr == rd_addr) |=> held == $past(wr.data))
      else $error("key map forwarding returned stale data");

   // No transaction writes the map while the sweep runs
   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !wr.en && !rd_en)
      else $error("key map accessed during clearing sweep");

   // The sweep ends only after the last entry
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> clr_addr_ff == '0)
      else $error("key map sweep ended early");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/scd_decode.sv @@
// Scan byte decoder: prefix, pause, caps lock and shift tracking, character
// ROM selection and the key map write request. Uses scd_pkg.
`default_nettype none

module scd_decode
   import scd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [SCAN_W-1:0] scan_byte,
   output map_wr_type             map_wr,
   output dec_result_type         result
);

   logic             prefix_ff, prefix_in;
   logic             pause_ff, pause_in;
   logic             caps_ff, caps_in;
   logic             lshift_ff, lshift_in;
   logic             rshift_ff, rshift_in;
   logic [KEY_W-1:0] last_make_ff, last_make_in;

   logic              is_prefix;
   logic              is_pause;
   logic              is_fake_shift;
   logic              is_key;
   logic              is_make;
   logic [KEY_W-1:0]  key;
   logic [CHAR_W-1:0] ch;
   logic [CHAR_W-1:0] ch_shift;
   logic [CHAR_W-1:0] ch_plain;

   // Classify the byte
   assign key           = scan_byte[KEY_W-1:0];
   assign is_prefix     = (scan_byte == SCAN_EXT_PREFIX);
   assign is_pause      = (scan_byte == SCAN_PAUSE);
   assign is_fake_shift = prefix_ff && ((key == KEY_LSHIFT) || (key == KEY_RSHIFT));
   assign is_key        = !is_prefix && !is_pause && !is_fake_shift;
   assign is_make       = is_key && !scan_byte[SCAN_W-1];

   // Next flag values
   always_comb begin
      prefix_in    = prefix_ff;
      pause_in     = pause_ff;
      caps_in      = caps_ff;
      lshift_in    = lshift_ff;
      rshift_in    = rshift_ff;
      last_make_in = last_make_ff;
      if (accept) begin
         if (is_prefix) begin
            prefix_in = 1'b1;
         end else if (is_pause) begin
            pause_in = !pause_ff;
         end else begin
            prefix_in = 1'b0;
         end
         if (is_key && (key == KEY_LSHIFT)) begin
            lshift_in = !scan_byte[SCAN_W-1];
         end
         if (is_key && (key == KEY_RSHIFT)) begin
            rshift_in = !scan_byte[SCAN_W-1];
         end
         if (is_make) begin
            last_make_in = key;
            if (!prefix_ff && (key == KEY_CAPS)) begin
               caps_in = !caps_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff    <= 1'b0;
         pause_ff     <= 1'b0;
         caps_ff      <= 1'b0;
         lshift_ff    <= 1'b0;
         rshift_ff    <= 1'b0;
         last_make_ff <= '0;
      end else begin
         prefix_ff    <= prefix_in;
         pause_ff     <= pause_in;
         caps_ff      <= caps_in;
         lshift_ff    <= lshift_in;
         rshift_ff    <= rshift_in;
         last_make_ff <= last_make_in;
      end
   end

   // Pick the character; caps lock flips letter case on the non-extended paths
   always_comb begin
      ch_shift = rom_shift(key);
      ch_plain = rom_plain(key);
      if (caps_in && (ch_shift >= CHAR_UPPER_A) && (ch_shift <= CHAR_UPPER_Z)) begin
         ch_shift = ch_shift + CASE_OFFSET;
      end
      if (caps_in && (ch_plain >= CHAR_LOWER_A) && (ch_plain <= CHAR_LOWER_Z)) begin
         ch_plain = ch_plain - CASE_OFFSET;
      end
      if (!is_make) begin
         ch = '0;
      end else if (prefix_ff) begin
         ch = rom_ext(key);
      end else if (lshift_in || rshift_in) begin
         ch = ch_shift;
      end else begin
         ch = ch_plain;
      end
   end

   assign map_wr.en   = accept && is_key;
   assign map_wr.addr = key;
   assign map_wr.data = !scan_byte[SCAN_W-1];

   assign result.char_valid  = (ch != '0);
   assign result.char_code   = ch;
   assign result.last_make   = last_make_in;
   assign result.pause_on    = pause_in;
   assign result.capslock_on = caps_in;

`ifndef ASSERT_OFF
   // Only an E0 byte raises the prefix
   a_prefix_source: assert property (@(posedge clock) disable iff (reset)
      $rose(prefix_ff) |-> $past(accept && is_prefix))
      else $error("extended prefix set without E0 byte");

   // Pause flips only on an E1 byte
   a_pause_source: assert property (@(posedge clock) disable iff (reset)
      (pause_ff != $past(pause_ff)) |-> $past(accept && is_pause))
      else $error("pause flag changed without E1 byte");

   // A dropped fake shift touches neither the map nor the character
   a_fake_drop: assert property (@(posedge clock) disable iff (reset)
      accept && is_fake_shift |-> !map_wr.en && !result.char_valid)
      else $error("fake shift was not dropped");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/scan_code_to_ascii_decoder.sv @@
// Top level of the set-1 scan code to ASCII decoder: decode stage, key map
// RAM and output register. Depends on scd_pkg, scd_req_if, scd_rsp_if,
// scd_decode and scd_key_map.
//
//   channel   dir   fields
//   req_ch    in    scan_byte[7:0], probe_key[6:0]
//   rsp_ch    out   char_valid, char_code[6:0], last_make[6:0], pause_on,
//                   capslock_on, probe_down
//
// One transaction per clock unless rsp_ch stalls; a taken request passes the
// key map RAM read stage and then the output register that drives rsp_ch.
// After reset a sweep clears the key map, one entry a cycle; req_ch.ready
// stays low until all 128 entries are clear.
// A stalled response holds in the output register while one more request is
// taken into the RAM read stage; ready drops only when both are full.
`default_nettype none

module scan_code_to_ascii_decoder
   import scd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   scd_req_if.sink    req_ch,
   scd_rsp_if.source  rsp_ch
);

   logic           accept;
   logic           clear_busy;
   logic           held;
   map_wr_type     map_wr;
   dec_result_type dec_result;

   logic           s1_valid_ff, s1_valid_in;
   dec_result_type s1_res_ff;
   logic           s1_advance;
   logic           out_valid_ff, out_valid_in;
   dec_result_type out_res_ff;
   logic           out_probe_ff;

   // Advance the read stage into the output register when it is free
   assign s1_advance   = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !clear_busy && (!s1_valid_ff || s1_advance);
   assign accept       = req_ch.valid && req_ch.ready;

   scd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .scan_byte (req_ch.scan_byte),
      .map_wr    (map_wr),
      .result    (dec_result)
   );

   scd_key_map u_key_map (
      .clock      (clock),
      .reset      (reset),
      .wr         (map_wr),
      .rd_en      (accept),
      .rd_addr    (req_ch.probe_key),
      .held       (held),
      .clear_busy (clear_busy)
   );

   // Stage valid bits
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: hold decoded fields while the RAM read completes, then register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= dec_result;
      end
      if (s1_advance) begin
         out_res_ff   <= s1_res_ff;
         out_probe_ff <= held;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.char_valid  = out_res_ff.char_valid;
   assign rsp_ch.char_code   = out_res_ff.char_code;
   assign rsp_ch.last_make   = out_res_ff.last_make;
   assign rsp_ch.pause_on    = out_res_ff.pause_on;
   assign rsp_ch.capslock_on = out_res_ff.capslock_on;
   assign rsp_ch.probe_down  = out_probe_ff;

`ifndef ASSERT_OFF
   // A stalled response keeps its contents
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> out_valid_ff && $stable(out_res_ff)
         && $stable(out_probe_ff))
      else $error("stalled response changed");

   // The read stage never loses a transaction
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_res_ff))
      else $error("read stage dropped a transaction");

   // Nothing is taken while the key map is being cleared
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !accept && !s1_valid_ff)
      else $error("transaction during key map sweep");
`endif

endmodule

`default_nettype wire

@@ sim/scan_code_to_ascii_decoder_tb.sv @@
// Self-checking testbench for the set-1 scan code to ASCII decoder.
// Depends on scd_pkg, scd_req_if, scd_rsp_if and the scan_code_to_ascii_decoder RTL.
`timescale 1ns / 1ps

module scan_code_to_ascii_decoder_tb
   import scd_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [KEY_W-1:0] KEY_KP_ENTER = 7'h1C;
   localparam logic [KEY_W-1:0] KEY_KP_SLASH = 7'h35;
   localparam logic [KEY_W-1:0] KEY_NUM_LOCK = 7'h45;
   localparam logic [KEY_W-1:0] KEY_CTRL     = 7'h1D;
   localparam logic [KEY_W-1:0] KEY_DELETE   = 7'h53;
   localparam logic [KEY_W-1:0] KEY_LETTER_A = 7'h1E;

   typedef enum int {ROM_PLAIN, ROM_SHIFT, ROM_EXT} rom_sel_type;

   // One decoded response, probe bit included
   typedef struct packed {
      logic              char_valid;
      logic [CHAR_W-1:0] char_code;
      logic [KEY_W-1:0]  last_make;
      logic              pause_on;
      logic              capslock_on;
      logic              probe_down;
   } scan_result_type;

   // Tracks keyboard state and the queue of characters the block owes us
   class scan_decode_checker;
      bit [CHAR_W-1:0]   char_rom [3][NUM_KEYS];
      bit [NUM_KEYS-1:0] held_keys;
      bit                prefix_seen;
      bit                pause_state;
      bit                caps_state;
      bit [KEY_W-1:0]    last_make_key;
      scan_result_type   expected_chars[$];
      int                mismatches;

      function void put_text(rom_sel_type sel, int first, string text);
         for (int i = 0; i < text.len(); i++)
            char_rom[sel][first + i] = CHAR_W'(text[i]);
      endfunction

      function new();
         char_rom = '{default: '0};
         held_keys = '0;
         prefix_seen = 1'b0;
         pause_state = 1'b0;
         caps_state = 1'b0;
         last_make_key = '0;
         mismatches = 0;
         // keys shared by plain and shifted layouts
         for (int t = ROM_PLAIN; t <= ROM_SHIFT; t++) begin
            char_rom[t][7'h01] = 7'd27;
            char_rom[t][7'h0E] = 7'd8;
            char_rom[t][7'h0F] = 7'd9;
            char_rom[t][7'h1C] = 7'd13;
            char_rom[t][7'h37] = 7'd42;
            char_rom[t][7'h39] = 7'd32;
            char_rom[t][7'h4A] = 7'd45;
            char_rom[t][7'h4E] = 7'd43;
            char_rom[t][KEY_DELETE] = 7'd127;
         end
         put_text(ROM_PLAIN, 'h02, "1234567890-=");
         put_text(ROM_PLAIN, 'h10, "qwertyuiop[]");
         put_text(ROM_PLAIN, 'h1E, "asdfghjkl;'");
         char_rom[ROM_PLAIN][7'h29] = 7'd96;
         put_text(ROM_PLAIN, 'h2B, "\\zxcvbnm,./");
         put_text(ROM_SHIFT, 'h02, "!@#$%^&*()_+");
         put_text(ROM_SHIFT, 'h10, "QWERTYUIOP{}");
         put_text(ROM_SHIFT, 'h1E, "ASDFGHJKL:\"~");
         put_text(ROM_SHIFT, 'h2B, "|ZXCVBNM<>?");
         char_rom[ROM_EXT][KEY_KP_ENTER] = 7'd13;
         char_rom[ROM_EXT][KEY_KP_SLASH] = 7'd47;
      endfunction

      function int outstanding();
         return expected_chars.size();
      endfunction

      // Advance the keyboard state by one accepted scan byte and queue its result
      function void note_scan(logic [SCAN_W-1:0] scan, logic [KEY_W-1:0] probe);
         scan_result_type   res;
         logic [KEY_W-1:0]  key;
         logic [CHAR_W-1:0] ch;
         key = scan[KEY_W-1:0];
         ch = '0;
         if (scan == SCAN_EXT_PREFIX) begin
            prefix_seen = 1'b1;
         end else if (scan == SCAN_PAUSE) begin
            pause_state = ~pause_state;
         end else if (prefix_seen && (key == KEY_LSHIFT || key == KEY_RSHIFT)) begin
            // drop fake shift make and break after the prefix
            prefix_seen = 1'b0;
         end else begin
            if (scan[SCAN_W-1]) begin
               held_keys[key] = 1'b0;
            end else begin
               last_make_key = key;
               held_keys[key] = 1'b1;
               if (prefix_seen) begin
                  ch = char_rom[ROM_EXT][key];
               end else begin
                  if (key == KEY_CAPS)
                     caps_state = ~caps_state;
                  if (held_keys[KEY_LSHIFT] || held_keys[KEY_RSHIFT]) begin
                     ch = char_rom[ROM_SHIFT][key];
                     if (caps_state && ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
                        ch = ch + CASE_OFFSET;
                  end else begin
                     ch = char_rom[ROM_PLAIN][key];
                     if (caps_state && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
                        ch = ch - CASE_OFFSET;
                  end
               end
            end
            prefix_seen = 1'b0;
         end
         res.char_valid  = (ch != '0);
         res.char_code   = ch;
         res.last_make   = last_make_key;
         res.pause_on    = pause_state;
         res.capslock_on = caps_state;
         res.probe_down  = held_keys[probe];
         expected_chars.push_back(res);
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
         end
      endfunction

      // Compare one accepted response with the oldest queued expectation
      function void check_char(scan_result_type got);
         scan_result_type exp_res;
         if (expected_chars.size() == 0) begin
            $error("response with nothing expected: char_code %0d", got.char_code);
            mismatches++;
            return;
         end
         exp_res = expected_chars.pop_front();
         compare_field("char_valid", exp_res.char_valid, got.char_valid);
         compare_field("char_code", exp_res.char_code, got.char_code);
         compare_field("last_make", exp_res.last_make, got.last_make);
         compare_field("pause_on", exp_res.pause_on, got.pause_on);
         compare_field("capslock_on", exp_res.capslock_on, got.capslock_on);
         compare_field("probe_down", exp_res.probe_down, got.probe_down);
      endfunction
   endclass

   logic clock;
   logic reset;
   scd_req_if req_ch();
   scd_rsp_if rsp_ch();

   scan_decode_checker board = new();
   int send_idle_pct = 8;
   int recv_idle_pct = 78;
   int rx_hold_left = 0;
   int sent_count = 0;
   int cycle_count = 0;

   scan_code_to_ascii_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one scan byte, idling first at random, and hold it until taken
   task automatic send_item(input logic [SCAN_W-1:0] scan, input logic [KEY_W-1:0] probe);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.scan_byte <= scan;
      req_ch.probe_key <= probe;
      do begin
         @(posedge clock);
      end while (req_ch.ready !== 1'b1);
      board.note_scan(scan, probe);
      sent_count++;
   endtask

   // Drop valid and wait for every owed response
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.outstanding() != 0)
         @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_probe(logic [KEY_W-1:0] key);
      int sel;
      sel = $urandom_range(3);
      if (sel == 0)
         return key;
      if (sel == 1)
         return $urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT;
      return KEY_W'($urandom_range(NUM_KEYS - 1));
   endfunction

   task automatic key_down(input logic [KEY_W-1:0] key);
      send_item({1'b0, key}, pick_probe(key));
   endtask

   task automatic key_up(input logic [KEY_W-1:0] key);
      send_item({1'b1, key}, pick_probe(key));
   endtask

   task automatic send_code(input logic [SCAN_W-1:0] scan);
      send_item(scan, pick_probe(scan[KEY_W-1:0]));
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(1))
         return KEY_W'($urandom_range(NUM_KEYS - 1));
      return KEY_W'($urandom_range(1, KEY_DELETE));
   endfunction

   // One random keyboard gesture, mostly well formed, some noise
   task automatic type_burst();
      int               pick;
      int               taps;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] shift_key;
      pick = $urandom_range(99);
      key = pick_key();
      if (pick < 35) begin
         key_down(key);
         if ($urandom_range(3) == 0) begin
            key_down(KEY_LETTER_A);
            key_up(KEY_LETTER_A);
         end
         key_up(key);
      end else if (pick < 50) begin
         shift_key = $urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT;
         taps = $urandom_range(1, 4);
         key_down(shift_key);
         repeat (taps) begin
            key = pick_key();
            key_down(key);
            key_up(key);
         end
         if ($urandom_range(9) != 0)
            key_up(shift_key);
      end else if (pick < 60) begin
         taps = $urandom_range(2);
         key = (taps == 0) ? KEY_KP_ENTER : (taps == 1) ? KEY_KP_SLASH : key;
         send_code(SCAN_EXT_PREFIX);
         key_down(key);
         send_code(SCAN_EXT_PREFIX);
         key_up(key);
      end else if (pick < 65) begin
         shift_key = $urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT;
         send_code(SCAN_EXT_PREFIX);
         send_code({1'($urandom_range(1)), shift_key});
         key_down(key);
         key_up(key);
      end else if (pick < 72) begin
         if ($urandom_range(3) == 0)
            send_code(SCAN_EXT_PREFIX);
         key_down(KEY_CAPS);
         key_up(KEY_CAPS);
      end else if (pick < 76) begin
         send_code(SCAN_PAUSE);
         key_down(KEY_CTRL);
         key_down(KEY_NUM_LOCK);
         send_code(SCAN_PAUSE);
         key_up(KEY_CTRL);
         key_up(KEY_NUM_LOCK);
      end else begin
         taps = $urandom_range(1, 4);
         repeat (taps)
            send_code(SCAN_W'($urandom_range(255)));
      end
   endtask

   // Accept responses, stalling at random or for a requested hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_char({rsp_ch.char_valid, rsp_ch.char_code, rsp_ch.last_make,
                              rsp_ch.pause_on, rsp_ch.capslock_on, rsp_ch.probe_down});
      end
   end

   // Bound the run length
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.scan_byte = '0;
      req_ch.probe_key = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero entries, case handling, prefix and pause corners
      send_item(8'h00, 7'h00);
      send_item(8'h7F, 7'h7F);
      send_item(8'hFF, 7'h7F);
      key_down(KEY_LETTER_A);
      key_down(KEY_CAPS);
      key_down(KEY_LETTER_A);
      key_down(KEY_RSHIFT);
      key_down(KEY_LETTER_A);
      send_item(8'h02, KEY_RSHIFT);
      key_up(KEY_RSHIFT);
      key_up(KEY_CAPS);
      send_code(SCAN_EXT_PREFIX);
      send_item({1'b0, KEY_CAPS}, KEY_CAPS);
      send_code(SCAN_EXT_PREFIX);
      send_item({1'b0, KEY_LSHIFT}, KEY_LSHIFT);
      send_item(8'h10, KEY_LSHIFT);
      send_code(SCAN_EXT_PREFIX);
      send_code(SCAN_PAUSE);
      send_item({1'b0, KEY_KP_SLASH}, KEY_KP_SLASH);
      send_code(SCAN_EXT_PREFIX);
      send_item({1'b1, KEY_KP_ENTER}, KEY_KP_ENTER);
      key_down(KEY_DELETE);
      send_code(SCAN_PAUSE);
      send_item(8'h80, 7'h00);
      key_down(KEY_CAPS);

      // Sender mostly busy, receiver mostly stalled
      while (sent_count < 310)
         type_burst();
      wait_drained();

      // Sender mostly idle, receiver mostly ready
      send_idle_pct = 78;
      recv_idle_pct = 8;
      while (sent_count < 590)
         type_burst();
      wait_drained();

      // Full rate, with one long receiver hold-off to back up the input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (sent_count < 620)
         type_burst();
      rx_hold_left = 60;
      while (sent_count < 850)
         type_burst();
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
